### rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg: shared definitions of the Mandelbrot escape-time engine
// Formats, constants, request and result types and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  localparam int unsigned FracBits  = 28;
  localparam int unsigned CountBits = 16;
  localparam int unsigned CW        = 32;
  localparam int unsigned ZW        = 36;
  localparam int unsigned MulAW     = 38;
  localparam int unsigned MulHalf   = MulAW / 2;
  localparam int unsigned PartW     = MulAW + MulHalf + 1;
  localparam int unsigned ProdW     = 2 * MulAW;
  localparam int unsigned TruncW    = ProdW - FracBits;
  localparam int unsigned SqW       = 2 * ZW;

  localparam logic [MulAW-1:0]  Quarter   = MulAW'(1) << (FracBits - 2);
  localparam logic [MulAW-1:0]  One       = MulAW'(1) << FracBits;
  localparam logic [TruncW:0]   BulbBound = (TruncW + 1)'(1) << (FracBits - 4);
  localparam logic [SqW:0]      EscBound  = (SqW + 1)'(1) << (2 * FracBits + 2);
  localparam logic [CountBits-1:0] LimitReset = CountBits'(256);

  typedef struct packed {
    logic signed [CW-1:0] c_real;
    logic signed [CW-1:0] c_imag;
  } mbe_in_t;

  typedef struct packed {
    logic [CountBits-1:0] iteration_count;
    logic                 escaped;
    logic                 known_interior;
    logic signed [ZW-1:0] final_z_real;
    logic signed [ZW-1:0] final_z_imag;
  } mbe_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8,
    ST_I0, ST_I1, ST_I2, ST_I3, ST_I4, ST_I5, ST_I6,
    ST_DONE
  } mbe_state_e;

endpackage

`default_nettype wire

### rtl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time count of one point c
// Cardioid and period-2 bulb tests, then z = z*z + c until |z|^2 > 4 or the iteration limit is reached.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake               Payload
//   in        request    in_valid_i/in_stall_o    in_data_i  (c_real, c_imag)
//   out       result     out_valid_o/out_stall_i  out_data_o (count, flags, z)
//   cfg       write      cfg_we_i                 cfg_wdata_i (iteration_limit)
//
// A point ends after the test states ST_C0 to ST_C8 when the interior tests
// settle it; else each update runs through ST_I0 to ST_I6 until it escapes
// or reaches the limit n, as each of three products takes two passes
// through one 38 by 20 bit multiplier. Reset clears the sequencer and the
// output valid and sets the limit to 256. A stalled result stays in the output
// register while the next request is taken; that result waits for it to free.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire mbe_pkg::mbe_in_t                  in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output mbe_pkg::mbe_out_t                      out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [mbe_pkg::CountBits-1:0]     cfg_wdata_i
);

  localparam int unsigned AW = mbe_pkg::MulAW;
  localparam int unsigned HW = mbe_pkg::MulHalf;
  localparam int unsigned PW = mbe_pkg::ProdW;
  localparam int unsigned TW = mbe_pkg::TruncW;
  localparam int unsigned SW = mbe_pkg::SqW;
  localparam int unsigned FB = mbe_pkg::FracBits;
  localparam int unsigned ZW = mbe_pkg::ZW;
  localparam int unsigned NW = mbe_pkg::CountBits;

  mbe_pkg::mbe_state_e state_q, state_d;

  logic [NW-1:0]              lim_q;
  logic signed [mbe_pkg::CW-1:0] cr_q, ci_q;
  logic signed [ZW-1:0]       zr_q, zi_q;
  logic [NW-1:0]              cnt_q;
  logic signed [TW-1:0]       ci2_q;
  logic signed [AW-1:0]       q_q, qx_q;
  logic                       bulb_q;
  logic                       interior_q;
  logic [SW-1:0]              sqr_q, sqi_q;
  logic signed [mbe_pkg::PartW-1:0] acc_q;
  mbe_pkg::mbe_out_t          out_q;
  logic                       out_valid_q;

  logic signed [AW-1:0]       mul_a, mul_b;
  logic                       mul_hi;
  logic [HW-1:0]              mul_b_part;
  logic signed [mbe_pkg::PartW-1:0] part;
  logic signed [PW-1:0]       prod_full;
  logic signed [TW-1:0]       trunc;
  logic signed [AW-1:0]       xc, xb;
  logic signed [TW:0]         q_sum;
  logic signed [TW:0]         bulb_sum;
  logic                       card;
  logic                       escape;
  logic [ZW-1:0]              zr_d, zi_d;
  logic                       accept;
  logic                       out_load;

  assign xc = AW'(cr_q) - mbe_pkg::Quarter;
  assign xb = AW'(cr_q) + mbe_pkg::One;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_hi = 1'b0;
    unique case (state_q) inside
      mbe_pkg::ST_C0, mbe_pkg::ST_C1: begin
        mul_a = AW'(ci_q);
        mul_b = AW'(ci_q);
      end
      mbe_pkg::ST_C2, mbe_pkg::ST_C3: begin
        mul_a = xc;
        mul_b = xc;
      end
      mbe_pkg::ST_C4, mbe_pkg::ST_C5: begin
        mul_a = xb;
        mul_b = xb;
      end
      mbe_pkg::ST_C6, mbe_pkg::ST_C7: begin
        mul_a = q_q;
        mul_b = qx_q;
      end
      mbe_pkg::ST_I0, mbe_pkg::ST_I1: begin
        mul_a = AW'(zr_q);
        mul_b = AW'(zr_q);
      end
      mbe_pkg::ST_I2, mbe_pkg::ST_I3: begin
        mul_a = AW'(zi_q);
        mul_b = AW'(zi_q);
      end
      mbe_pkg::ST_I4, mbe_pkg::ST_I5: begin
        mul_a = AW'(zr_q);
        mul_b = AW'(zi_q);
      end
      default: begin
      end
    endcase
    unique case (state_q) inside
      mbe_pkg::ST_C1, mbe_pkg::ST_C3, mbe_pkg::ST_C5, mbe_pkg::ST_C7,
      mbe_pkg::ST_I1, mbe_pkg::ST_I3, mbe_pkg::ST_I5: mul_hi = 1'b1;
      default: mul_hi = 1'b0;
    endcase
  end

  assign mul_b_part = mul_hi ? mul_b[AW-1:HW] : mul_b[HW-1:0];

  mbe_mul u_mul (
    .clk_i      (clk_i),
    .a_i        (mul_a),
    .b_i        (mul_b_part),
    .b_signed_i (mul_hi),
    .p_o        (part)
  );

  // The low pass is held in acc_q while the high pass sits in the multiplier's
  // output register; the full product is the sum of the two.
  assign prod_full = (PW'(part) <<< HW) + PW'(acc_q);
  assign trunc     = prod_full[PW-1:FB];

  assign q_sum    = (TW + 1)'(trunc) + (TW + 1)'(ci2_q);
  assign bulb_sum = q_sum;
  assign card     = trunc <= (ci2_q >>> 2);
  assign escape   = ((SW + 1)'(sqr_q) + (SW + 1)'(sqi_q)) > mbe_pkg::EscBound;

  assign zr_d = sqr_q[FB+ZW-1:FB] - sqi_q[FB+ZW-1:FB] + ZW'(cr_q);
  assign zi_d = {trunc[ZW-2:0], 1'b0} + ZW'(ci_q);

  assign accept   = in_valid_i && (state_q == mbe_pkg::ST_IDLE);
  assign out_load = (state_q == mbe_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbe_pkg::ST_IDLE: if (in_valid_i) state_d = mbe_pkg::ST_C0;
      mbe_pkg::ST_C0:   state_d = mbe_pkg::ST_C1;
      mbe_pkg::ST_C1:   state_d = mbe_pkg::ST_C2;
      mbe_pkg::ST_C2:   state_d = mbe_pkg::ST_C3;
      mbe_pkg::ST_C3:   state_d = mbe_pkg::ST_C4;
      mbe_pkg::ST_C4:   state_d = mbe_pkg::ST_C5;
      mbe_pkg::ST_C5:   state_d = mbe_pkg::ST_C6;
      mbe_pkg::ST_C6:   state_d = mbe_pkg::ST_C7;
      mbe_pkg::ST_C7:   state_d = mbe_pkg::ST_C8;
      mbe_pkg::ST_C8: begin
        state_d = (card || bulb_q) ? mbe_pkg::ST_DONE : mbe_pkg::ST_I0;
      end
      mbe_pkg::ST_I0: begin
        state_d = (cnt_q == lim_q) ? mbe_pkg::ST_DONE : mbe_pkg::ST_I1;
      end
      mbe_pkg::ST_I1:   state_d = mbe_pkg::ST_I2;
      mbe_pkg::ST_I2:   state_d = mbe_pkg::ST_I3;
      mbe_pkg::ST_I3:   state_d = mbe_pkg::ST_I4;
      mbe_pkg::ST_I4:   state_d = mbe_pkg::ST_I5;
      mbe_pkg::ST_I5:   state_d = escape ? mbe_pkg::ST_DONE : mbe_pkg::ST_I6;
      mbe_pkg::ST_I6:   state_d = mbe_pkg::ST_I0;
      mbe_pkg::ST_DONE: if (out_load) state_d = mbe_pkg::ST_IDLE;
      default:          state_d = mbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbe_pkg::ST_IDLE;
      lim_q       <= mbe_pkg::LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= part;
    if (accept) begin
      cr_q  <= in_data_i.c_real;
      ci_q  <= in_data_i.c_imag;
      zr_q  <= '0;
      zi_q  <= '0;
      cnt_q <= '0;
    end
    unique case (state_q)
      mbe_pkg::ST_C2: ci2_q  <= trunc;
      mbe_pkg::ST_C4: q_q    <= q_sum[AW-1:0];
      mbe_pkg::ST_C5: qx_q   <= q_q + xc;
      mbe_pkg::ST_C6: bulb_q <= bulb_sum <= $signed(mbe_pkg::BulbBound);
      mbe_pkg::ST_C8: begin
        interior_q <= card || bulb_q;
        if (card || bulb_q) begin
          cnt_q <= lim_q;
        end
      end
      mbe_pkg::ST_I2: sqr_q <= prod_full[SW-1:0];
      mbe_pkg::ST_I4: sqi_q <= prod_full[SW-1:0];
      mbe_pkg::ST_I6: begin
        zr_q  <= zr_d;
        zi_q  <= zi_d;
        cnt_q <= cnt_q + NW'(1);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q.iteration_count <= cnt_q;
      out_q.escaped         <= cnt_q < lim_q;
      out_q.known_interior  <= interior_q;
      out_q.final_z_real    <= zr_q;
      out_q.final_z_imag    <= zi_q;
    end
  end

  assign in_stall_o  = (state_q != mbe_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/mbe_mul.sv
// ----------------------------------------------------------------------------
// mbe_mul: shared partial-product multiplier
// Multiplies a signed operand by one half of another operand, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul (
  input  wire logic                                   clk_i,
  input  wire logic signed [mbe_pkg::MulAW-1:0]       a_i,
  input  wire logic        [mbe_pkg::MulHalf-1:0]     b_i,
  input  wire logic                                   b_signed_i,
  output logic signed      [mbe_pkg::PartW-1:0]       p_o
);

  logic signed [mbe_pkg::MulHalf:0]   b_ext;
  logic signed [mbe_pkg::PartW-1:0]   p_q;

  assign b_ext = {b_signed_i & b_i[mbe_pkg::MulHalf-1], b_i};

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_ext;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire
